@@ hdl/sidx_pkg.sv @@
// ----------------------------------------------------------------------------
// Segment index box parser package
// Shared types and constants for the parser controller and datapath.
// ----------------------------------------------------------------------------
package sidx_pkg;

   localparam logic [31:0] BOX_TYPE_SIDX = 32'h73696478;
   localparam logic [31:0] SIZE_MASK = 32'h7FFFFFFF;
   localparam logic [3:0] REF_BYTES = 4'd12;
   localparam int QUOT_W = 48;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TRUNCATED = 3'd1,
      ST_BAD_TYPE  = 3'd2,
      ST_ZERO_TS   = 3'd3,
      ST_NO_REFS   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ACTIVE,
      PH_DIVIDE,
      PH_OUTPUT,
      PH_DONE
   } phase_type;

   // Controller to datapath.
   typedef struct packed {
      logic       take_byte;
      logic       start_div;
      logic       div_step;
      logic       commit_entry;
      logic       load_out;
      logic       out_kind;
      status_type out_status;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic       emit;
      logic       emit_entry;
      status_type emit_status;
      logic       div_done;
      logic       out_full;
   } stat_type;

endpackage

@@ hdl/segment_index_box_parser.sv @@
// ----------------------------------------------------------------------------
// Segment index box parser
// Parses segment index box bytes into segment entries and one summary.
// ----------------------------------------------------------------------------
// A byte without a result is taken while the controller is idle. A byte that yields
// a summary stalls the input through the output phase, which loads the registered
// summary. A byte that closes a reference duration also stalls the input through the
// divide phase of the radix-2 divider before its entry is loaded the same way.
// A stalled waiting result delays the next result byte further.
// Synchronous active-high reset returns the parser to idle with no result waiting.
module segment_index_box_parser #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_first_byte,
   input  logic [31:0]        req_box_length,
   input  logic signed [63:0] req_sidx_end_offset,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_kind,
   output logic signed [63:0] rsp_segment_offset,
   output logic [30:0]        rsp_segment_size,
   output logic [47:0]        rsp_segment_duration,
   output logic [63:0]        rsp_total_duration,
   output logic [31:0]        rsp_time_scale,
   output logic [2:0]         rsp_parse_status,
   output logic               rsp_index_valid,
   output logic               rsp_last_result
);
   import sidx_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   sidx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sidx_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_data_byte        (req_data_byte),
      .req_first_byte       (req_first_byte),
      .req_box_length       (req_box_length),
      .req_sidx_end_offset  (req_sidx_end_offset),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_segment_offset   (rsp_segment_offset),
      .rsp_segment_size     (rsp_segment_size),
      .rsp_segment_duration (rsp_segment_duration),
      .rsp_total_duration   (rsp_total_duration),
      .rsp_time_scale       (rsp_time_scale),
      .rsp_parse_status     (rsp_parse_status),
      .rsp_index_valid      (rsp_index_valid),
      .rsp_last_result      (rsp_last_result)
   );

endmodule

@@ hdl/sidx_ctrl.sv @@
// ----------------------------------------------------------------------------
// Segment index parser controller
// Sequences byte intake, the divider and result delivery.
// ----------------------------------------------------------------------------
module sidx_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sidx_pkg::stat_type stat,
   output sidx_pkg::cmd_type cmd
);
   import sidx_pkg::*;

   phase_type phase_ff, phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      cmd = '0;
      cmd.out_status = ST_OK;
      req_stall = 1'b1;
      unique case (phase_ff)
         PH_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take_byte = 1'b1;
               if (stat.emit && stat.emit_entry) begin
                  cmd.start_div = 1'b1;
                  phase_in = PH_DIVIDE;
               end else if (stat.emit) begin
                  phase_in = PH_OUTPUT;
               end
            end
         end
         PH_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               phase_in = PH_OUTPUT;
            end
         end
         PH_OUTPUT: begin
            if (!stat.out_full) begin
               cmd.load_out = 1'b1;
               cmd.out_kind = !stat.emit_entry;
               cmd.out_status = stat.emit_status;
               cmd.commit_entry = stat.emit_entry;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !stat.out_full)
      else $error("result loaded over a waiting result");
   assert property (@(posedge clock) disable iff (reset)
      cmd.start_div |=> phase_ff == PH_DIVIDE)
      else $error("divider start without divide phase");
   assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> req_stall)
      else $error("byte taken while busy");

endmodule

@@ hdl/sidx_datapath.sv @@
// ----------------------------------------------------------------------------
// Segment index parser datapath
// Field parsing, a radix-2 divider and the result register.
// ----------------------------------------------------------------------------
module sidx_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sidx_pkg::cmd_type      cmd,
   output sidx_pkg::stat_type     stat,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_first_byte,
   input  logic [31:0]            req_box_length,
   input  logic signed [63:0]     req_sidx_end_offset,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic                   rsp_result_kind,
   output logic signed [63:0]     rsp_segment_offset,
   output logic [30:0]            rsp_segment_size,
   output logic [47:0]            rsp_segment_duration,
   output logic [63:0]            rsp_total_duration,
   output logic [31:0]            rsp_time_scale,
   output logic [2:0]             rsp_parse_status,
   output logic                   rsp_index_valid,
   output logic                   rsp_last_result
);
   import sidx_pkg::*;

   localparam int DIV_W = 32 + FRAC_BITS;
   localparam int CNT_W = $clog2(DIV_W + 1);

   logic        active_ff;
   logic [31:0] pos_ff;
   logic [63:0] shift_ff;
   logic        ver1_ff, large_ff;
   logic [31:0] ts_ff;
   logic [15:0] refs_ff;
   logic [63:0] run_ff, sum_ff, end_ff;
   logic [31:0] len_ff;
   logic [30:0] esize_ff;
   logic        any_ff;
   logic [3:0]  rmod_ff;
   logic        emit_entry_ff;
   status_type  emit_status_ff;

   logic [DIV_W-1:0] dq_ff;
   logic [32:0]      drem_ff;
   logic [CNT_W-1:0] dcnt_ff;
   logic [47:0]      quot;

   logic        out_full_ff;

   // Per-byte decode.
   logic        act;
   logic [31:0] p;
   logic [63:0] sh;
   logic [31:0] lo;
   logic [31:0] blen;
   logic [5:0]  hdr, tsend, elen, pstart;
   logic        emit, emit_entry;
   status_type  est;
   logic [34:0] need;

   always_comb begin
      act = active_ff;
      p = pos_ff;
      blen = len_ff;
      if (req_first_byte) begin
         act = 1'b1;
         p = '0;
         blen = req_box_length;
      end
      sh = req_first_byte ? {56'd0, req_data_byte} : {shift_ff[55:0], req_data_byte};
      lo = sh[31:0];
      hdr = (large_ff && !req_first_byte) ? 6'd16 : 6'd8;
      tsend = hdr + 6'd12;
      elen = (ver1_ff && !req_first_byte) ? 6'd8 : 6'd4;
      pstart = tsend + {elen[4:0], 1'b0} + 6'd4;
      need = 35'(pstart) + 35'(lo[15:0]) * 35'd12;
      emit = 1'b0;
      emit_entry = 1'b0;
      est = ST_OK;
      if (req_first_byte && req_box_length < 32'd12) begin
         emit = 1'b1;
         est = ST_TRUNCATED;
      end else if (act) begin
         if (p == 32'd7) begin
            if (lo != BOX_TYPE_SIDX) begin
               emit = 1'b1;
               est = ST_BAD_TYPE;
            end else if (32'(large_ff ? 6'd28 : 6'd20) > blen) begin
               emit = 1'b1;
               est = ST_TRUNCATED;
            end
         end else if (p >= 32'd8 && p != 32'(hdr) && p == 32'(tsend) - 32'd1) begin
            if (lo == '0) begin
               emit = 1'b1;
               est = ST_ZERO_TS;
            end else if (32'(pstart) > blen) begin
               emit = 1'b1;
               est = ST_TRUNCATED;
            end
         end else if (p >= 32'd8 && p == 32'(pstart) - 32'd1) begin
            if (need > 35'(blen)) begin
               emit = 1'b1;
               est = ST_TRUNCATED;
            end else if (lo[15:0] == '0) begin
               emit = 1'b1;
               est = ST_NO_REFS;
            end
         end else if (p >= 32'(pstart)) begin
            if (rmod_ff == 4'd7) begin
               emit = 1'b1;
               emit_entry = 1'b1;
            end else if (rmod_ff == 4'd11 && refs_ff == 16'd1) begin
               emit = 1'b1;
               est = ST_OK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff <= '0;
         shift_ff <= '0;
         ver1_ff <= 1'b0;
         large_ff <= 1'b0;
         ts_ff <= '0;
         refs_ff <= '0;
         run_ff <= '0;
         sum_ff <= '0;
         len_ff <= '0;
         end_ff <= '0;
         esize_ff <= '0;
         any_ff <= 1'b0;
         rmod_ff <= '0;
         out_full_ff <= 1'b0;
         dcnt_ff <= '0;
      end else begin
         if (cmd.take_byte) begin
            emit_entry_ff <= emit_entry;
            emit_status_ff <= est;
            if (req_first_byte) begin
               ver1_ff <= 1'b0;
               large_ff <= 1'b0;
               ts_ff <= '0;
               refs_ff <= '0;
               run_ff <= '0;
               sum_ff <= '0;
               esize_ff <= '0;
               any_ff <= 1'b0;
               rmod_ff <= '0;
               len_ff <= req_box_length;
               end_ff <= req_sidx_end_offset;
            end
            if (act) begin
               shift_ff <= sh;
               pos_ff <= p + 32'd1;
               if (emit && !emit_entry) begin
                  active_ff <= 1'b0;
               end else begin
                  active_ff <= 1'b1;
               end
               if (p == 32'd3) begin
                  large_ff <= (lo == 32'd1);
               end else if (p >= 32'd8) begin
                  if (p == 32'(hdr)) begin
                     ver1_ff <= (req_data_byte != 8'd0);
                  end else if (p == 32'(tsend) - 32'd1) begin
                     ts_ff <= lo;
                  end else if (p == 32'(tsend) + 32'({elen[4:0], 1'b0}) - 32'd1) begin
                     run_ff <= end_ff + (ver1_ff ? sh : {32'd0, lo});
                  end else if (p == 32'(pstart) - 32'd1) begin
                     refs_ff <= lo[15:0];
                     rmod_ff <= '0;
                  end else if (p >= 32'(pstart)) begin
                     rmod_ff <= (rmod_ff == REF_BYTES - 4'd1) ? 4'd0 : rmod_ff + 4'd1;
                     if (rmod_ff == 4'd3) begin
                        esize_ff <= lo[30:0];
                     end else if (rmod_ff == 4'd11) begin
                        refs_ff <= refs_ff - 16'd1;
                     end
                  end
               end
            end
         end
         if (cmd.start_div) begin
            dq_ff <= DIV_W'(lo) << FRAC_BITS;
            drem_ff <= '0;
            dcnt_ff <= CNT_W'(DIV_W);
         end else if (cmd.div_step && dcnt_ff != '0) begin
            if ({drem_ff[31:0], dq_ff[DIV_W-1]} >= {1'b0, ts_ff}) begin
               drem_ff <= {drem_ff[31:0], dq_ff[DIV_W-1]} - {1'b0, ts_ff};
               dq_ff <= {dq_ff[DIV_W-2:0], 1'b1};
            end else begin
               drem_ff <= {drem_ff[31:0], dq_ff[DIV_W-1]};
               dq_ff <= {dq_ff[DIV_W-2:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff - CNT_W'(1);
         end
         if (cmd.commit_entry) begin
            run_ff <= run_ff + {33'd0, esize_ff};
            sum_ff <= sum_ff + {16'd0, quot};
            any_ff <= 1'b1;
         end
         if (cmd.load_out) begin
            out_full_ff <= 1'b1;
         end else if (rsp_valid && !rsp_stall) begin
            out_full_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      if (DIV_W > QUOT_W && (dq_ff >> QUOT_W) != '0) begin
         quot = '1;
      end else begin
         quot = QUOT_W'(dq_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_result_kind <= cmd.out_kind;
         rsp_last_result <= cmd.out_kind;
         if (cmd.out_kind) begin
            rsp_segment_offset <= '0;
            rsp_segment_size <= '0;
            rsp_segment_duration <= '0;
            rsp_total_duration <= sum_ff;
            rsp_time_scale <= ts_ff;
            rsp_parse_status <= cmd.out_status;
            rsp_index_valid <= any_ff;
         end else begin
            rsp_segment_offset <= run_ff;
            rsp_segment_size <= esize_ff;
            rsp_segment_duration <= quot;
            rsp_total_duration <= '0;
            rsp_time_scale <= '0;
            rsp_parse_status <= '0;
            rsp_index_valid <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_full_ff;

   always_comb begin
      stat.emit = emit;
      stat.emit_entry = cmd.take_byte ? emit_entry : emit_entry_ff;
      stat.emit_status = emit_status_ff;
      stat.div_done = (dcnt_ff == '0);
      stat.out_full = out_full_ff && rsp_stall;
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.commit_entry |-> ts_ff != '0)
      else $error("entry committed with zero timescale");
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid)
      else $error("loaded result not presented");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind |-> rsp_last_result)
      else $error("summary without last flag");

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// Segment index box parser testbench
// Feeds directed and random segment index boxes byte by byte, predicts every
// segment entry and summary, and compares each result beat field by field.
// ----------------------------------------------------------------------------
module tb;
   import sidx_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam longint LIMIT = 3000000;

   typedef struct packed {
      logic        kind;
      logic [63:0] offset;
      logic [30:0] size;
      logic [47:0] dur;
      logic [63:0] total;
      logic [31:0] tscale;
      logic [2:0]  status;
      logic        valid_idx;
      logic        last;
   } result_type;

   typedef struct {
      logic [7:0]  data;
      logic        first;
      logic [31:0] blen;
      logic [63:0] eoff;
   } byte_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_data_byte;
   logic               req_first_byte;
   logic [31:0]        req_box_length;
   logic signed [63:0] req_sidx_end_offset;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_result_kind;
   logic signed [63:0] rsp_segment_offset;
   logic [30:0]        rsp_segment_size;
   logic [47:0]        rsp_segment_duration;
   logic [63:0]        rsp_total_duration;
   logic [31:0]        rsp_time_scale;
   logic [2:0]         rsp_parse_status;
   logic               rsp_index_valid;
   logic               rsp_last_result;

   segment_index_box_parser #(.FRAC_BITS(FRAC_BITS)) dut (.*);

   // Predictor state.
   logic        p_active;
   logic [31:0] p_pos;
   logic [63:0] p_shift;
   logic        p_ver1;
   logic        p_large;
   logic [31:0] p_tscale;
   logic [15:0] p_refs;
   logic [63:0] p_offset;
   logic [63:0] p_sum;
   logic [31:0] p_blen;
   logic [63:0] p_eoff;
   logic [30:0] p_size;
   logic        p_any;

   result_type expected_results[$];
   byte_type   box_bytes[$];
   byte_type   directed_rows[$];
   result_type directed_expect[$];
   int         directed_has_expect[$];
   longint     cycles;
   int         errors;
   int         send_idle_pct;
   int         recv_stall_pct;
   logic       hold_off;

   function automatic result_type summary_of(status_type st);
      result_type r;
      r = '0;
      r.kind = 1'b1;
      r.total = p_sum;
      r.tscale = p_tscale;
      r.status = st;
      r.valid_idx = p_any;
      r.last = 1'b1;
      p_active = 1'b0;
      return r;
   endfunction

   function automatic void predict_clear();
      p_active = 1'b0;
      p_pos = '0;
      p_shift = '0;
      p_ver1 = 1'b0;
      p_large = 1'b0;
      p_tscale = '0;
      p_refs = '0;
      p_offset = '0;
      p_sum = '0;
      p_size = '0;
      p_any = 1'b0;
   endfunction

   // Returns 1 when the byte yields a result, placed in r.
   function automatic bit predict_byte(byte_type b, output result_type r);
      logic [31:0] low32;
      longint unsigned pp, hdr, tsend, elen, pstart, len, rr, q, first;
      r = '0;
      if (b.first) begin
         predict_clear();
         p_blen = b.blen;
         p_eoff = b.eoff;
         p_active = 1'b1;
         if (b.blen < 12) begin
            r = summary_of(ST_TRUNCATED);
            return 1;
         end
      end
      if (!p_active) return 0;
      p_shift = {p_shift[55:0], b.data};
      low32 = p_shift[31:0];
      pp = p_pos;
      p_pos = p_pos + 1;
      len = p_blen;
      hdr = p_large ? 16 : 8;
      tsend = hdr + 12;
      elen = p_ver1 ? 8 : 4;
      pstart = tsend + 2 * elen + 4;
      if (pp == 3) begin
         p_large = (low32 == 1);
         return 0;
      end
      if (pp == 7) begin
         hdr = p_large ? 16 : 8;
         if (low32 != BOX_TYPE_SIDX) begin
            r = summary_of(ST_BAD_TYPE);
            return 1;
         end
         if (hdr + 12 > len) begin
            r = summary_of(ST_TRUNCATED);
            return 1;
         end
         return 0;
      end
      if (pp < 8) return 0;
      if (pp == hdr) begin
         p_ver1 = (b.data != 0);
         return 0;
      end
      if (pp == tsend - 1) begin
         p_tscale = low32;
         if (low32 == 0) begin
            r = summary_of(ST_ZERO_TS);
            return 1;
         end
         if (pstart > len) begin
            r = summary_of(ST_TRUNCATED);
            return 1;
         end
         return 0;
      end
      if (pp == tsend + 2 * elen - 1) begin
         first = p_ver1 ? p_shift : {32'd0, low32};
         p_offset = p_eoff + first;
         return 0;
      end
      if (pp == pstart - 1) begin
         p_refs = low32[15:0];
         if (pstart + longint'(p_refs) * 12 > len) begin
            r = summary_of(ST_TRUNCATED);
            return 1;
         end
         if (p_refs == 0) begin
            r = summary_of(ST_NO_REFS);
            return 1;
         end
         return 0;
      end
      if (pp >= pstart) begin
         rr = (pp - pstart) % 12;
         if (rr == 3) begin
            p_size = low32[30:0];
         end else if (rr == 7) begin
            q = ({32'd0, low32} << FRAC_BITS) / {32'd0, p_tscale};
            if (q > 64'hFFFF_FFFF_FFFF) q = 64'hFFFF_FFFF_FFFF;
            r.offset = p_offset;
            r.size = p_size;
            r.dur = q[47:0];
            p_offset = p_offset + p_size;
            p_sum = p_sum + q;
            p_any = 1'b1;
            return 1;
         end else if (rr == 11) begin
            p_refs = p_refs - 1;
            if (p_refs == 0) begin
               r = summary_of(ST_OK);
               return 1;
            end
         end
      end
      return 0;
   endfunction

   function automatic void push_word(logic [63:0] v, int n);
      byte_type b;
      for (int i = n - 1; i >= 0; i--) begin
         b.data = v[8*i +: 8];
         b.first = 1'b0;
         b.blen = $urandom;
         b.eoff = {$urandom, $urandom};
         box_bytes.insert(box_bytes.size(), b);
      end
   endfunction

   // Builds a box; mode picks a fault: 0 good, 1 bad type, 2 zero timescale,
   // 3 reference overrun, 4 short length, 5 cut in the header.
   function automatic void build_box(int nrefs, int mode, bit ver1, bit wide_hdr,
                                     logic [31:0] tscale_v);
      int total, hlen;
      logic [31:0] blen;
      logic [63:0] eoff;
      hlen = (wide_hdr ? 16 : 8) + 12 + (ver1 ? 16 : 8) + 4;
      total = hlen + 12 * nrefs;
      blen = 32'(total + int'($urandom_range(0, 3)));
      if (mode == 3) blen = 32'(total - int'($urandom_range(1, 12)));
      if (mode == 4) blen = $urandom_range(0, 11);
      if (mode == 5) blen = $urandom_range(12, hlen - 1);
      eoff = {$urandom, $urandom};
      push_word(64'(wide_hdr ? 1 : total), 4);
      push_word(64'(mode == 1 ? $urandom : BOX_TYPE_SIDX), 4);
      box_bytes[box_bytes.size() - 8].first = 1'b1;
      box_bytes[box_bytes.size() - 8].blen = blen;
      box_bytes[box_bytes.size() - 8].eoff = eoff;
      if (wide_hdr) push_word({$urandom, $urandom}, 8);
      push_word(64'(ver1 ? $urandom_range(1, 255) : 0), 1);
      push_word(64'($urandom), 3);
      push_word(64'($urandom), 4);
      push_word(64'(mode == 2 ? 32'd0 : tscale_v), 4);
      push_word({$urandom, $urandom}, ver1 ? 8 : 4);
      push_word({$urandom, $urandom}, ver1 ? 8 : 4);
      push_word(64'($urandom), 2);
      push_word(64'(nrefs), 2);
      for (int i = 0; i < nrefs; i++) begin
         push_word(64'($urandom), 4);
         push_word(64'($urandom_range(0, 3) == 0 ? 32'hFFFFFFFF : $urandom), 4);
         push_word(64'($urandom), 4);
      end
   endfunction

   task automatic send_beat(byte_type b);
      result_type r;
      while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b.data;
      req_first_byte <= b.first;
      req_box_length <= b.blen;
      req_sidx_end_offset <= b.eoff;
      do @(posedge clock); while (req_stall);
      if (predict_byte(b, r)) expected_results.insert(expected_results.size(), r);
      @(negedge clock);
   endtask

   task automatic release_req();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_all();
      while (box_bytes.size() > 0) send_beat(box_bytes.pop_front());
      release_req();
   endtask

   task automatic drain();
      while (expected_results.size() > 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b1;
      else if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_result_kind, rsp_segment_offset, rsp_segment_size,
                rsp_segment_duration, rsp_total_duration, rsp_time_scale,
                rsp_parse_status, rsp_index_valid, rsp_last_result};
         if (expected_results.size() == 0) begin
            $display("%0t unexpected beat: expected none actual %h", $time, got);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (got.kind !== want.kind || got.offset !== want.offset ||
                got.size !== want.size || got.dur !== want.dur ||
                got.total !== want.total || got.tscale !== want.tscale ||
                got.status !== want.status || got.valid_idx !== want.valid_idx ||
                got.last !== want.last) begin
               $display("%0t mismatch: expected %h actual %h", $time, want, got);
               errors++;
            end
         end
      end
   end

   initial begin
      byte_type    b;
      result_type  r;
      int          mode;
      cycles = 0;
      errors = 0;
      hold_off = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_first_byte = 1'b0;
      req_box_length = '0;
      req_sidx_end_offset = '0;
      rsp_stall = 1'b1;
      reset = 1'b1;
      predict_clear();
      p_blen = '0;
      p_eoff = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: stray byte while idle, short boxes, a stray byte after them.
      directed_rows.insert(directed_rows.size(),
                           '{8'hFF, 1'b0, 32'hFFFFFFFF, 64'h7FFFFFFFFFFFFFFF});
      directed_has_expect.insert(directed_has_expect.size(), 0);
      directed_expect.insert(directed_expect.size(), '0);
      directed_rows.insert(directed_rows.size(),
                           '{8'h00, 1'b1, 32'd0, 64'h8000000000000000});
      directed_has_expect.insert(directed_has_expect.size(), 1);
      directed_expect.insert(directed_expect.size(),
                             '{1'b1, 64'd0, 31'd0, 48'd0, 64'd0, 32'd0,
                               ST_TRUNCATED, 1'b0, 1'b1});
      directed_rows.insert(directed_rows.size(), '{8'h55, 1'b1, 32'd11, 64'd0});
      directed_has_expect.insert(directed_has_expect.size(), 1);
      directed_expect.insert(directed_expect.size(),
                             '{1'b1, 64'd0, 31'd0, 48'd0, 64'd0, 32'd0,
                               ST_TRUNCATED, 1'b0, 1'b1});
      directed_rows.insert(directed_rows.size(), '{8'hAA, 1'b0, 32'd0, 64'd0});
      directed_has_expect.insert(directed_has_expect.size(), 0);
      directed_expect.insert(directed_expect.size(), '0);
      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i]);
         if (directed_has_expect[i]) begin
            r = expected_results[$];
            if (r !== directed_expect[i]) begin
               $display("%0t directed row %0d: expected %h actual %h",
                        $time, i, directed_expect[i], r);
               errors++;
            end
         end
      end
      release_req();
      for (mode = 0; mode <= 5; mode++) begin
         build_box(mode == 3 ? 2 : 1, mode, mode[0], mode[1], 32'hFFFFFFFF);
      end
      build_box(0, 0, 1'b0, 1'b0, 32'd1);
      build_box(2, 0, 1'b1, 1'b1, 32'd1);
      send_all();
      drain();

      // Random phases with different idling.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 25 : 88) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 25 : 88) : 0;
         while (box_bytes.size() < 100) begin
            mode = $urandom_range(0, 9);
            if (mode > 5) mode = 0;
            build_box($urandom_range(0, 4), mode, $urandom_range(0, 1),
                      $urandom_range(0, 1),
                      $urandom_range(0, 1) ? $urandom : $urandom_range(1, 1000));
            if ($urandom_range(0, 7) == 0) push_word(64'($urandom), 1);
         end
         if (ph == 0) begin
            fork
               begin
                  hold_off = 1'b1;
                  repeat (400) @(negedge clock);
                  hold_off = 1'b0;
               end
               send_all();
            join
         end else begin
            send_all();
         end
         drain();
      end

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
